/* rtl/bbs_pkg.sv */
`default_nettype none

package bbs_pkg;

  localparam int ID_W = 16;
  localparam int TS_W = 64;
  localparam int DIR_W = 2;
  localparam int WL_W = 9;
  localparam int BW_W = 12;
  localparam int CFG_DW = 12;
  localparam int CFG_IW = 8;

  localparam int DIG = 8;
  localparam int RHS_SHIFT = 16;

  localparam logic [CFG_IW-1:0] REG_WINDOW_LENGTH = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_BAND_WIDTH = CFG_IW'(1);

  localparam logic [WL_W-1:0] WINDOW_RESET = WL_W'(20);
  localparam logic [BW_W-1:0] BAND_RESET = BW_W'(512);
  localparam logic [WL_W-1:0] WINDOW_MIN = WL_W'(2);

  localparam logic [DIR_W-1:0] DIR_BUY = DIR_W'(0);
  localparam logic [DIR_W-1:0] DIR_SELL = DIR_W'(1);
  localparam logic [DIR_W-1:0] DIR_EXIT = DIR_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OLD,
    ST_NEW,
    ST_NP,
    ST_A2,
    ST_KK,
    ST_KKN,
    ST_NQ,
    ST_D,
    ST_LHS,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic sub;
  } mac_ctrl_t;

  typedef struct packed {
    logic active;
    logic done;
  } mac_stat_t;

endpackage

`default_nettype wire

/* rtl/bbs_ram.sv */
`default_nettype none

module bbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/bbs_mac.sv */
`default_nettype none

module bbs_mac #(
  parameter int ACC_W = 99,
  parameter int MUL_W = 33
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bbs_pkg::mac_ctrl_t  ctrl,
  input  wire logic [ACC_W-1:0]    init,
  input  wire logic [ACC_W-1:0]    mcand_in,
  input  wire logic [MUL_W-1:0]    mplier_in,
  output bbs_pkg::mac_stat_t       stat,
  output logic      [ACC_W-1:0]    result
);

  import bbs_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] mcand;
  logic [MUL_W-1:0] mplier;
  logic             active;
  logic             sub;
  logic [ACC_W+DIG-1:0] prod;

  assign prod = {{DIG{1'b0}}, mcand} * (ACC_W+DIG)'(mplier[DIG-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.start) begin
      active <= 1'b1;
    end else if (active && mplier == '0) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc    <= init;
      mcand  <= mcand_in;
      mplier <= mplier_in;
      sub    <= ctrl.sub;
    end else if (active && mplier != '0) begin
      acc    <= sub ? acc - prod[ACC_W-1:0] : acc + prod[ACC_W-1:0];
      mcand  <= mcand << DIG;
      mplier <= mplier >> DIG;
    end
  end

  assign stat.active = active;
  assign stat.done   = active && (mplier == '0);
  assign result      = acc;

endmodule

`default_nettype wire

/* rtl/bollinger_band_signal.sv */
// Bollinger band signal generator.
// s_axis carries price ticks: tdata = inst_id, time_stamp, price from
// bit 0 up. m_axis carries trade signals: tdata = inst_id_out,
// time_stamp_out, signal_price; tuser = direction (buy, sell, exit).
// The cfg channel writes window_length (index 0) or band_width_q8 (index 1);
// a window_length write empties the window and keeps the position flag.
// One tick is taken at a time. Each tick runs a sequence of products on a
// single shift-and-add multiply-accumulate unit that consumes 8 multiplier
// bits per cycle, so the product sequence sets the tick time: a tick that
// leaves the window short of full runs only the square of the new price,
// and a full window adds the band test (each product ends early when its
// remaining multiplier bits are zero). After the sequence ends, ST_EMIT
// loads a signal into the output register, at most one per tick.
// The result sits in an output register; a new tick is taken while it
// waits. If the receiver stalls and the next tick also signals, that tick
// holds in its last step until the register frees.
// Reset empties the window, closes the position and restores
// window_length 20 and band_width_q8 512 (k = 2.0).
`default_nettype none

module bollinger_band_signal #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,

  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // inst_id, time_stamp, price
  input  wire logic [((bbs_pkg::ID_W+bbs_pkg::TS_W+PRICE_BITS+7)/8)*8-1:0] s_axis_tdata,

  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // inst_id_out, time_stamp_out, signal_price
  output logic [((bbs_pkg::ID_W+bbs_pkg::TS_W+PRICE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // direction
  output logic [bbs_pkg::DIR_W-1:0] m_axis_tuser,

  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bbs_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [bbs_pkg::CFG_DW-1:0]  cfg_data
);

  import bbs_pkg::*;

  localparam int PW    = PRICE_BITS;
  localparam int DATAW = ((ID_W + TS_W + PW + 7) / 8) * 8;
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int SW    = PW + PTR_W;
  localparam int QW    = 2 * PW + PTR_W;
  localparam int NPW   = PW + NW;
  localparam int AAW   = (SW > NPW) ? SW : NPW;
  localparam int A2W   = 2 * AAW;
  localparam int KKNW  = 2 * BW_W + NW;
  localparam int LW    = QW + NW + KKNW;
  localparam int RW    = A2W + NW + RHS_SHIFT;
  localparam int AW    = (LW > RW) ? LW : RW;
  localparam int CW    = AW + 1;
  localparam int MW    = (AAW > KKNW) ? AAW : KKNW;

  state_t state, state_next;

  logic [WL_W-1:0]  window_length;
  logic [BW_W-1:0]  band_width;
  logic [NW-1:0]    win_n;

  logic [PTR_W-1:0] wp;
  logic [NW-1:0]    fill;
  logic [SW-1:0]    s_sum;
  logic [QW-1:0]    q_sum;
  logic             position_open;
  logic             eval;

  logic [ID_W-1:0]  id_r;
  logic [TS_W-1:0]  ts_r;
  logic [PW-1:0]    price_r;
  logic [PW-1:0]    old_p;
  logic [PW-1:0]    ram_rd;

  logic             s_gt;
  logic             s_lt;
  logic [AAW-1:0]   dev;
  logic [A2W-1:0]   a2;
  logic [KKNW-1:0]  kkn;
  logic             lt;

  logic             out_valid;
  logic [ID_W-1:0]  out_id;
  logic [TS_W-1:0]  out_ts;
  logic [DIR_W-1:0] out_dir;
  logic [PW-1:0]    out_price;

  mac_ctrl_t        mac_ctl;
  mac_stat_t        mac_st;
  logic [CW-1:0]    mac_init;
  logic [CW-1:0]    mac_a;
  logic [MW-1:0]    mac_b;
  logic [CW-1:0]    mac_res;
  logic [CW-1:0]    d_clamp;

  logic             in_acc;
  logic             cfg_acc;
  logic             full_before;
  logic [NW-1:0]    fill_inc;
  logic [AAW-1:0]   np_ext;
  logic [AAW-1:0]   s_ext;
  logic             fire_buy;
  logic             fire_sell;
  logic             fire_exit;
  logic             fire;
  logic             load_out;
  logic [DIR_W-1:0] dir_next;

  always_comb begin
    if (window_length < WINDOW_MIN) begin
      win_n = NW'(WINDOW_MIN);
    end else if (int'(window_length) > MAX_WINDOW) begin
      win_n = NW'(MAX_WINDOW);
    end else begin
      win_n = NW'(window_length);
    end
  end

  assign cfg_ready     = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;

  assign full_before = (fill >= win_n);
  assign fill_inc    = fill + NW'(1);
  assign d_clamp     = mac_res[CW-1] ? '0 : mac_res;

  assign np_ext = AAW'(mac_res[NPW-1:0]);
  assign s_ext  = AAW'(s_sum);

  assign fire_buy  = s_gt && lt && !position_open;
  assign fire_sell = s_lt && lt && position_open;
  assign fire_exit = !s_gt && position_open && !fire_sell;
  assign fire      = fire_buy || fire_sell || fire_exit;
  assign load_out  = (state == ST_EMIT) && fire && !(out_valid && !m_axis_tready);

  always_comb begin
    if (fire_buy) begin
      dir_next = DIR_BUY;
    end else if (fire_sell) begin
      dir_next = DIR_SELL;
    end else begin
      dir_next = DIR_EXIT;
    end
  end

  bbs_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (state == ST_LOAD),
    .wr_addr(wp),
    .wr_data(price_r),
    .rd_addr(wp),
    .rd_data(ram_rd)
  );

  bbs_mac #(
    .ACC_W(CW),
    .MUL_W(MW)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctl),
    .init     (mac_init),
    .mcand_in (mac_a),
    .mplier_in(mac_b),
    .stat     (mac_st),
    .result   (mac_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) state_next = ST_LOAD;
      ST_LOAD: state_next = full_before ? ST_OLD : ST_NEW;
      ST_OLD:  if (mac_st.done) state_next = ST_NEW;
      ST_NEW:  if (mac_st.done) state_next = eval ? ST_NP : ST_IDLE;
      ST_NP:   if (mac_st.done) state_next = ST_A2;
      ST_A2:   if (mac_st.done) state_next = ST_KK;
      ST_KK:   if (mac_st.done) state_next = ST_KKN;
      ST_KKN:  if (mac_st.done) state_next = ST_NQ;
      ST_NQ:   if (mac_st.done) state_next = ST_D;
      ST_D:    if (mac_st.done) state_next = ST_LHS;
      ST_LHS:  if (mac_st.done) state_next = ST_CMP;
      ST_CMP:  if (mac_st.done) state_next = ST_EMIT;
      ST_EMIT: if (!(fire && out_valid && !m_axis_tready)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl.start = (state inside {ST_OLD, ST_NEW, ST_NP, ST_A2, ST_KK, ST_KKN,
                                   ST_NQ, ST_D, ST_LHS, ST_CMP}) && !mac_st.active;
    mac_ctl.sub   = 1'b0;
    mac_init      = '0;
    mac_a         = '0;
    mac_b         = '0;
    case (state)
      ST_OLD: begin
        mac_ctl.sub = 1'b1;
        mac_init    = CW'(q_sum);
        mac_a       = CW'(old_p);
        mac_b       = MW'(old_p);
      end
      ST_NEW: begin
        mac_init = CW'(q_sum);
        mac_a    = CW'(price_r);
        mac_b    = MW'(price_r);
      end
      ST_NP: begin
        mac_a = CW'(price_r);
        mac_b = MW'(win_n);
      end
      ST_A2: begin
        mac_a = CW'(dev);
        mac_b = MW'(dev);
      end
      ST_KK: begin
        mac_a = CW'(band_width);
        mac_b = MW'(band_width);
      end
      ST_KKN: begin
        mac_a = CW'(kkn);
        mac_b = MW'(win_n);
      end
      ST_NQ: begin
        mac_a = CW'(q_sum);
        mac_b = MW'(win_n);
      end
      ST_D: begin
        mac_ctl.sub = 1'b1;
        mac_init    = mac_res;
        mac_a       = CW'(s_sum);
        mac_b       = MW'(s_sum);
      end
      ST_LHS: begin
        mac_a = d_clamp;
        mac_b = MW'(kkn);
      end
      ST_CMP: begin
        mac_ctl.sub = 1'b1;
        mac_init    = mac_res;
        mac_a       = CW'({a2, {RHS_SHIFT{1'b0}}});
        mac_b       = MW'(win_n - NW'(1));
      end
      default: begin
        mac_ctl.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      band_width    <= BAND_RESET;
      wp            <= '0;
      fill          <= '0;
      s_sum         <= '0;
      q_sum         <= '0;
      eval          <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          window_length <= cfg_data[WL_W-1:0];
          wp            <= '0;
          fill          <= '0;
          s_sum         <= '0;
          q_sum         <= '0;
        end
        REG_BAND_WIDTH: band_width <= cfg_data[BW_W-1:0];
        default: band_width <= band_width;
      endcase
    end else if (state == ST_LOAD) begin
      s_sum <= s_sum - (full_before ? SW'(ram_rd) : SW'(0)) + SW'(price_r);
      if (!full_before) begin
        fill <= fill_inc;
      end
      eval <= full_before || (fill_inc >= win_n);
      if (NW'(wp) + NW'(1) == win_n) begin
        wp <= '0;
      end else begin
        wp <= wp + PTR_W'(1);
      end
    end else if (mac_st.done && (state == ST_OLD || state == ST_NEW)) begin
      q_sum <= mac_res[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r    <= s_axis_tdata[ID_W-1:0];
      ts_r    <= s_axis_tdata[ID_W+TS_W-1:ID_W];
      price_r <= s_axis_tdata[ID_W+TS_W+PW-1:ID_W+TS_W];
    end
    if (state == ST_LOAD) begin
      old_p <= ram_rd;
    end
    if (mac_st.done) begin
      case (state)
        ST_NP: begin
          s_gt <= s_ext > np_ext;
          s_lt <= s_ext < np_ext;
          dev  <= (s_ext > np_ext) ? s_ext - np_ext : np_ext - s_ext;
        end
        ST_A2:  a2  <= mac_res[A2W-1:0];
        ST_KK:  kkn <= mac_res[KKNW-1:0];
        ST_KKN: kkn <= mac_res[KKNW-1:0];
        ST_CMP: lt  <= mac_res[CW-1];
        default: lt <= lt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      position_open <= 1'b0;
    end else if (load_out) begin
      out_valid     <= 1'b1;
      position_open <= (dir_next == DIR_BUY);
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id    <= id_r;
      out_ts    <= ts_r;
      out_dir   <= dir_next;
      out_price <= price_r;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATAW'({out_price, out_ts, out_id});
  assign m_axis_tuser  = out_dir;

  a_mac_no_restart: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.start |-> !mac_st.active)
    else $error("multiply unit restarted while running");

  a_ring_bounds: assert property (@(posedge clk) disable iff (rst)
    (NW'(wp) < win_n) && (fill <= win_n))
    else $error("ring pointer or fill count out of window");

  a_position_hold: assert property (@(posedge clk) disable iff (rst)
    !load_out |=> position_open == $past(position_open))
    else $error("position flag changed without a signal");

endmodule

`default_nettype wire
